>>> src/gm_nms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gm_nms_pkg: shared types and constants
// Payload structs, register indexes and controller command/status bundles.
// ----------------------------------------------------------------------------
package gm_nms_pkg;

    localparam int GRAD_BITS     = 12;
    localparam int GM_MAX_WIDTH  = 1024;
    localparam int SIZE_LIMIT    = 1024;
    localparam int CFG_BITS      = 11;
    localparam int POS_BITS      = 10;
    localparam int MAG_BITS      = 16;
    localparam int WEIGHT_BITS   = 9;
    localparam int SQRT_BITS     = 2 * GRAD_BITS + 10;
    localparam int ROOT_ITERS    = SQRT_BITS / 2;
    localparam int DIV_BITS      = GRAD_BITS + 9;
    localparam int DIV_ITERS     = DIV_BITS;
    localparam int CNT_BITS      = $clog2(DIV_ITERS);
    localparam int ACC_BITS      = MAG_BITS + WEIGHT_BITS + 1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic                        frame_start;
    } in_word_t;

    typedef struct packed {
        logic [POS_BITS-1:0] out_x;
        logic [POS_BITS-1:0] out_y;
        logic [MAG_BITS-1:0] nms_value;
        logic                frame_last;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic sq1;
        logic sq2;
        logic root_step;
        logic root_fin;
        logic win;
        logic div_init;
        logic div_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mul4;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic [GRAD_BITS-1:0] grad_abs(input logic [GRAD_BITS-1:0] v);
        logic [GRAD_BITS:0] e;
        e = {v[GRAD_BITS-1], v};
        if (v[GRAD_BITS-1]) begin
            e = ~e + 1'b1;
        end
        return e[GRAD_BITS-1:0];
    endfunction

endpackage

>>> src/gm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gm_ram: single-port line store
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module gm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/gm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gm_ctrl: per-pixel sequencer
// Steps one word through read, square, root, window, divide, interpolate.
// ----------------------------------------------------------------------------
module gm_ctrl import gm_nms_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [3:0] {
        IDLE, READ, SQ1, SQ2, ROOT, RFIN, WIN, DINIT, DIV,
        MUL1, MUL2, MUL3, MUL4, FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                ready_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            IDLE:   if (s_valid && ready_reg) state_next = READ;
            READ:   state_next = SQ1;
            SQ1:    state_next = SQ2;
            SQ2: begin
                state_next = ROOT;
                cnt_next   = CNT_BITS'(ROOT_ITERS - 1);
            end
            ROOT: begin
                if (cnt_reg == '0) state_next = RFIN;
                else cnt_next = cnt_reg - 1'b1;
            end
            RFIN:   state_next = WIN;
            WIN:    state_next = DINIT;
            DINIT: begin
                state_next = DIV;
                cnt_next   = CNT_BITS'(DIV_ITERS - 1);
            end
            DIV: begin
                if (cnt_reg == '0) state_next = MUL1;
                else cnt_next = cnt_reg - 1'b1;
            end
            MUL1:   state_next = MUL2;
            MUL2:   state_next = MUL3;
            MUL3:   state_next = MUL4;
            MUL4:   state_next = FINISH;
            FINISH: if (!status.out_busy) state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    assign s_ready = ready_reg;

    always_comb begin
        cmd           = '0;
        cmd.accept    = s_valid && ready_reg;
        cmd.sq1       = (state_reg == SQ1);
        cmd.sq2       = (state_reg == SQ2);
        cmd.root_step = (state_reg == ROOT);
        cmd.root_fin  = (state_reg == RFIN);
        cmd.win       = (state_reg == WIN);
        cmd.div_init  = (state_reg == DINIT);
        cmd.div_step  = (state_reg == DIV);
        cmd.mul1      = (state_reg == MUL1);
        cmd.mul2      = (state_reg == MUL2);
        cmd.mul3      = (state_reg == MUL3);
        cmd.mul4      = (state_reg == MUL4);
        cmd.finish    = (state_reg == FINISH) && !status.out_busy;
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> state_reg == IDLE) else $error("ready outside idle");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !ready_reg) else $error("ready right after accept");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> state_reg == IDLE) else $error("finish did not return to idle");

endmodule

>>> src/gm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gm_datapath: magnitude, line stores, window and suppression
// Separate squarers for x and y, iterative root and divider, one multiply per step.
// ----------------------------------------------------------------------------
module gm_datapath import gm_nms_pkg::*; #(
    parameter int MAX_WIDTH = GM_MAX_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  in_word_t            s_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WMAX = (MAX_WIDTH < SIZE_LIMIT) ? MAX_WIDTH : SIZE_LIMIT;
    localparam int GB   = GRAD_BITS;

    logic [CFG_BITS-1:0] width_reg, height_reg, w_eff, h_eff;
    logic [POS_BITS-1:0] col_reg, row_reg, pos_c_reg, pos_r_reg;
    logic [CFG_BITS-1:0] c0, r0, c1, r1;
    logic [GB-1:0]       gx_reg, gy_reg;
    logic                emit_reg, last_reg;

    logic [2*GB-1:0]      prod_reg;
    logic [2*GB-1:0]      sq_y;
    logic [SQRT_BITS-1:0] rem_reg, root_reg, bit_reg;
    logic [SQRT_BITS-1:0] trial, root_rnd;
    logic [MAG_BITS-1:0]  cur_reg;

    logic [MAG_BITS-1:0] older_rd, newer_rd;
    logic [2*GB-1:0]     grad_rd;
    logic [AW-1:0]       ram_addr;

    logic [MAG_BITS-1:0] win_reg [3][3];
    logic [2*GB-1:0]     gdelay_reg, cg_reg;

    logic [GB-1:0]       cgx, cgy, aax, aay;
    logic                same, ymaj;
    logic                zero_reg;
    logic [GB-1:0]       major_reg;
    logic [MAG_BITS-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [GB:0]         drem_reg;
    logic [DIV_BITS-1:0] dq_reg;
    logic [GB+1:0]       dtrial;
    logic [WEIGHT_BITS-1:0] w_wt, w_inv;
    logic [ACC_BITS-1:0] acc1_reg, acc2_reg, m_sh;
    logic                keep;
    logic                m_valid_reg;
    out_word_t           m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < CFG_BITS'(3)) w_eff = CFG_BITS'(3);
        else if (width_reg > CFG_BITS'(WMAX)) w_eff = CFG_BITS'(WMAX);
        else w_eff = width_reg;
        if (height_reg < CFG_BITS'(3)) h_eff = CFG_BITS'(3);
        else if (height_reg > CFG_BITS'(SIZE_LIMIT)) h_eff = CFG_BITS'(SIZE_LIMIT);
        else h_eff = height_reg;
    end

    // position of the incoming word
    always_comb begin
        c0 = s_data.frame_start ? '0 : CFG_BITS'(col_reg);
        r0 = s_data.frame_start ? '0 : CFG_BITS'(row_reg);
        if (c0 >= w_eff) begin
            c0 = '0;
            r0 = r0 + 1'b1;
        end
        if (r0 >= h_eff) r0 = '0;
        c1 = c0 + 1'b1;
        r1 = r0 + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (c1 >= w_eff) begin
                col_reg <= '0;
                row_reg <= (r1 >= h_eff) ? '0 : r1[POS_BITS-1:0];
            end else begin
                col_reg <= c1[POS_BITS-1:0];
                row_reg <= r0[POS_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pos_c_reg <= c0[POS_BITS-1:0];
            pos_r_reg <= r0[POS_BITS-1:0];
            gx_reg    <= s_data.grad_x;
            gy_reg    <= s_data.grad_y;
            emit_reg  <= (c0 >= CFG_BITS'(2)) && (r0 >= CFG_BITS'(2));
            last_reg  <= (c1 == w_eff) && (r1 == h_eff);
        end
    end

    // magnitude: squares then bit-pair square root
    assign trial = root_reg + bit_reg;
    assign root_rnd = root_reg + SQRT_BITS'(rem_reg > root_reg);
    assign sq_y = grad_abs(gy_reg) * grad_abs(gy_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sq1) begin
            prod_reg <= grad_abs(gx_reg) * grad_abs(gx_reg);
        end
        if (cmd.sq2) begin
            rem_reg  <= (SQRT_BITS'(prod_reg) + SQRT_BITS'(sq_y)) << 8;
            root_reg <= '0;
            bit_reg  <= SQRT_BITS'(1) << (SQRT_BITS - 2);
        end
        if (cmd.root_step) begin
            if (rem_reg >= trial) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.root_fin) begin
            cur_reg <= (root_rnd > SQRT_BITS'(16'hFFFF)) ? 16'hFFFF
                       : root_rnd[MAG_BITS-1:0];
        end
    end

    assign ram_addr = AW'(pos_c_reg);

    gm_ram #(.WIDTH(MAG_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .aclk(aclk), .we(cmd.win), .addr(ram_addr), .wdata(newer_rd), .rdata(older_rd)
    );
    gm_ram #(.WIDTH(MAG_BITS), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk(aclk), .we(cmd.win), .addr(ram_addr), .wdata(cur_reg), .rdata(newer_rd)
    );
    gm_ram #(.WIDTH(2*GB), .DEPTH(MAX_WIDTH)) u_grad (
        .aclk(aclk), .we(cmd.win), .addr(ram_addr), .wdata({gy_reg, gx_reg}),
        .rdata(grad_rd)
    );

    // advance the 3x3 window and the gradient of the center pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
            gdelay_reg <= '0;
            cg_reg     <= '0;
        end else if (cmd.win) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= older_rd;
            win_reg[1][2] <= newer_rd;
            win_reg[2][2] <= cur_reg;
            cg_reg        <= gdelay_reg;
            gdelay_reg    <= grad_rd;
        end
    end

    assign cgx  = cg_reg[GB-1:0];
    assign cgy  = cg_reg[2*GB-1:GB];
    assign aax  = grad_abs(cgx);
    assign aay  = grad_abs(cgy);
    assign same = ($signed(cgx) > 0 && $signed(cgy) > 0)
               || ($signed(cgx) < 0 && $signed(cgy) < 0);
    assign ymaj = aay > aax;

    assign dtrial = {drem_reg, dq_reg[DIV_BITS-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            zero_reg  <= (win_reg[1][1] == '0) || (aax == '0 && aay == '0);
            major_reg <= ymaj ? aay : aax;
            dq_reg    <= DIV_BITS'({(ymaj ? aax : aay), 8'b0})
                         + DIV_BITS'((ymaj ? aay : aax) >> 1);
            drem_reg  <= '0;
            if (ymaj) begin
                p2_reg <= win_reg[0][1];
                p4_reg <= win_reg[2][1];
                p1_reg <= same ? win_reg[0][0] : win_reg[0][2];
                p3_reg <= same ? win_reg[2][2] : win_reg[2][0];
            end else begin
                p2_reg <= win_reg[1][0];
                p4_reg <= win_reg[1][2];
                p1_reg <= same ? win_reg[0][0] : win_reg[2][0];
                p3_reg <= same ? win_reg[2][2] : win_reg[0][2];
            end
        end
        if (cmd.div_step) begin
            if (dtrial >= (GB+2)'(major_reg)) begin
                drem_reg <= (GB+1)'(dtrial - (GB+2)'(major_reg));
                dq_reg   <= {dq_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                drem_reg <= dtrial[GB:0];
                dq_reg   <= {dq_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    // interpolate: one product per step
    assign w_wt  = dq_reg[WEIGHT_BITS-1:0];
    assign w_inv = WEIGHT_BITS'(256) - w_wt;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) acc1_reg <= ACC_BITS'(w_wt) * ACC_BITS'(p1_reg);
        if (cmd.mul2) acc1_reg <= acc1_reg + ACC_BITS'(w_inv) * ACC_BITS'(p2_reg);
        if (cmd.mul3) acc2_reg <= ACC_BITS'(w_wt) * ACC_BITS'(p3_reg);
        if (cmd.mul4) acc2_reg <= acc2_reg + ACC_BITS'(w_inv) * ACC_BITS'(p4_reg);
    end

    assign m_sh = ACC_BITS'({win_reg[1][1], 8'b0});
    assign keep = !zero_reg && (m_sh >= acc1_reg) && (m_sh >= acc2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish && emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && emit_reg) begin
            m_data_reg.out_x      <= pos_c_reg - 1'b1;
            m_data_reg.out_y      <= pos_r_reg - 1'b1;
            m_data_reg.nms_value  <= keep ? win_reg[1][1] : '0;
            m_data_reg.frame_last <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.out_x != '0 && m_data_reg.out_y != '0)
        else $error("border pixel emitted");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_valid_reg || m_ready) else $error("result overwritten");
    a_rise_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish)) else $error("result without finish");

endmodule

>>> src/gradient_magnitude_nms_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_magnitude_nms_unit: interpolated Canny non-maximum suppression
// Streams gradient pairs, resolves each interior pixel one row and column late.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_data  (grad_x, grad_y, frame_start)
//  m_        out        m_valid / m_ready   m_data  (out_x, out_y, nms_value,
//                                                    frame_last)
//  cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
//  Each pixel runs through the 17-step square root and the 21-step weight
//  divider sharing one sequenced datapath before the next word is taken.
//  Reset is synchronous, active low; line stores need no clearing pass.
//  A pending result stalls only the final step; the next word is taken
//  while a result waits in the output register.
// ----------------------------------------------------------------------------
module gradient_magnitude_nms_unit import gm_nms_pkg::*; #(
    parameter int MAX_WIDTH = GM_MAX_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_word_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_word_t           m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    gm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .cmd(cmd), .status(status)
    );

    gm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .s_data(s_data), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule
